// File: src/mfd_pkg.sv
// Package for the Manchester frame decoder.
// Holds field widths, sample constants and the queue entry type; no dependencies.
package mfd_pkg;

  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 4;
  localparam int POS_W        = 8;
  localparam int WORD_W       = 37;
  localparam int PREFIX_W     = 4;
  localparam int ADDR_W       = 23;
  localparam int PRES_W       = 10;
  localparam int PREFIX_SHIFT = 33;
  localparam int ADDR_SHIFT   = 10;
  localparam int DATA_SAMPLES = 74;

  // One classified byte on its way from the front to the back.
  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              clear;
    logic [CNT_W-1:0]  count;
    logic              last;
  } q_entry_t;

endpackage

// File: src/mfd_front.sv
// Front of the Manchester frame decoder: accepts bytes, tracks the byte count.
// Depends on mfd_pkg.
module mfd_front #(
  parameter int FRAME_BYTES = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        q_full,
  input  logic [mfd_pkg::BYTE_W-1:0]  in_frame_byte,
  input  logic                        in_start_of_frame,
  output logic                        push,
  output mfd_pkg::q_entry_t           entry
);

  logic [mfd_pkg::CNT_W-1:0] cnt_r;
  logic [mfd_pkg::CNT_W-1:0] cnt_nxt;
  logic [mfd_pkg::CNT_W-1:0] cnt_eff;
  logic                      last;

  assign push    = in_valid && !q_full;
  // restart the count on a start flag
  assign cnt_eff = in_start_of_frame ? '0 : cnt_r;
  assign last    = cnt_eff >= mfd_pkg::CNT_W'(FRAME_BYTES - 1);
  assign cnt_nxt = last ? '0 : cnt_eff + 1'b1;

  assign entry.frame_byte = in_frame_byte;
  assign entry.clear      = in_start_of_frame;
  assign entry.count      = cnt_eff;
  assign entry.last       = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= cnt_nxt;
    end
  end

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    push && last |=> cnt_r == '0)
    else $error("byte count did not wrap after last byte");

endmodule

// File: src/mfd_queue.sv
// Short FIFO between front and back of the Manchester frame decoder.
// Depends on mfd_pkg.
module mfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mfd_pkg::q_entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              q_valid,
  output mfd_pkg::q_entry_t q_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mfd_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic [PW-1:0]     wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_nxt;

  assign full    = count_r == CW'(DEPTH);
  assign q_valid = count_r != '0;
  assign q_entry = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("pop from empty queue");

endmodule

// File: src/mfd_back.sv
// Back of the Manchester frame decoder: pairs samples, builds the word, emits results.
// Depends on mfd_pkg.
module mfd_back #(
  parameter int SKIP_SAMPLES = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  mfd_pkg::q_entry_t             q_entry,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mfd_pkg::PREFIX_W-1:0]  out_prefix_bits,
  output logic [mfd_pkg::ADDR_W-1:0]    out_sensor_address,
  output logic [mfd_pkg::PRES_W-1:0]    out_pressure_value,
  output logic                          out_code_error
);

  logic [mfd_pkg::WORD_W-1:0]   word_r;
  logic                         pend_r;
  logic                         err_r;
  logic [mfd_pkg::WORD_W-1:0]   word_nxt;
  logic                         pend_nxt;
  logic                         err_nxt;
  logic                         out_valid_r;
  logic [mfd_pkg::PREFIX_W-1:0] prefix_r;
  logic [mfd_pkg::ADDR_W-1:0]   addr_r;
  logic [mfd_pkg::PRES_W-1:0]   pres_r;
  logic                         code_err_r;
  logic                         can_take;

  // a byte that closes no frame never waits on the output register
  assign can_take = !q_entry.last || !out_valid_r || !out_stall;
  assign pop      = q_valid && can_take;

  always_comb begin
    logic [mfd_pkg::POS_W-1:0] pos;
    logic [mfd_pkg::POS_W-1:0] rel;
    logic                      smp;
    word_nxt = q_entry.clear ? '0 : word_r;
    pend_nxt = q_entry.clear ? 1'b0 : pend_r;
    err_nxt  = q_entry.clear ? 1'b0 : err_r;
    for (int b = 0; b < mfd_pkg::BYTE_W; b++) begin
      pos = {1'b0, q_entry.count, 3'(b)};
      rel = pos - mfd_pkg::POS_W'(SKIP_SAMPLES);
      smp = q_entry.frame_byte[3'(mfd_pkg::BYTE_W - 1 - b)];
      if (pos >= mfd_pkg::POS_W'(SKIP_SAMPLES) &&
          rel < mfd_pkg::POS_W'(mfd_pkg::DATA_SAMPLES)) begin
        if (!rel[0]) begin
          pend_nxt = smp;
        end else begin
          // 0-then-1 decodes to 1; 1-then-0 to 0; others flag an error
          if (pend_nxt == smp) begin
            err_nxt = 1'b1;
          end
          word_nxt = {word_nxt[mfd_pkg::WORD_W-2:0], !pend_nxt && smp};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r      <= '0;
      pend_r      <= 1'b0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        if (q_entry.last) begin
          out_valid_r <= 1'b1;
          word_r      <= '0;
          pend_r      <= 1'b0;
          err_r       <= 1'b0;
        end else begin
          word_r <= word_nxt;
          pend_r <= pend_nxt;
          err_r  <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      prefix_r   <= word_nxt[mfd_pkg::PREFIX_SHIFT +: mfd_pkg::PREFIX_W];
      addr_r     <= word_nxt[mfd_pkg::ADDR_SHIFT +: mfd_pkg::ADDR_W];
      pres_r     <= word_nxt[mfd_pkg::PRES_W-1:0];
      code_err_r <= err_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_prefix_bits    = prefix_r;
  assign out_sensor_address = addr_r;
  assign out_pressure_value = pres_r;
  assign out_code_error     = code_err_r;

  a_clear_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pop && q_entry.last |=> word_r == '0 && !pend_r && !err_r)
    else $error("decode state not cleared after frame");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pop && q_entry.last))
    else $error("result raised without a closing byte");

endmodule

// File: src/manchester_frame_decoder_top.sv
// Top level of the Manchester frame decoder.
// Instantiates mfd_front, mfd_queue and mfd_back; depends on mfd_pkg.
//
// Takes one received byte per cycle while in_stall is low (bit 7 is the earliest
// sample) and, on the last byte of each FRAME_BYTES-byte frame, emits one result:
// the 37 bits decoded from Manchester pairs after SKIP_SAMPLES skipped samples
// (1-then-0 is 0, 0-then-1 is 1), split into a 4-bit prefix, a 23-bit address and a
// 10-bit pressure, with a flag for any 00 or 11 pair. A start flag restarts a frame;
// after the last byte the next byte starts a new frame on its own. Throughput is one
// byte per cycle while no closing byte waits on a stalled result, set by the back
// stage that folds all eight samples of a byte in one step. With an empty queue a
// closing byte is first written into the two-entry queue when accepted, and the back
// stage then pops it and loads the result into the output register. A closing byte
// waits in the queue while the previous result is still stalled at the output; once
// the queue is full the input stalls.
module manchester_frame_decoder_top #(
  parameter int FRAME_BYTES  = 10,
  parameter int SKIP_SAMPLES = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mfd_pkg::BYTE_W-1:0]    in_frame_byte,
  input  logic                          in_start_of_frame,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mfd_pkg::PREFIX_W-1:0]  out_prefix_bits,
  output logic [mfd_pkg::ADDR_W-1:0]    out_sensor_address,
  output logic [mfd_pkg::PRES_W-1:0]    out_pressure_value,
  output logic                          out_code_error
);

  logic              q_full;
  logic              push;
  logic              pop;
  logic              q_valid;
  mfd_pkg::q_entry_t push_entry;
  mfd_pkg::q_entry_t q_entry;

  assign in_stall = q_full;

  mfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .q_full           (q_full),
    .in_frame_byte    (in_frame_byte),
    .in_start_of_frame(in_start_of_frame),
    .push             (push),
    .entry            (push_entry)
  );

  mfd_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_entry   (q_entry)
  );

  mfd_back #(
    .SKIP_SAMPLES(SKIP_SAMPLES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_entry           (q_entry),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prefix_bits   (out_prefix_bits),
    .out_sensor_address(out_sensor_address),
    .out_pressure_value(out_pressure_value),
    .out_code_error    (out_code_error)
  );

endmodule
